@@ hw/rtl/sdf_pkg.sv @@
// sdf_pkg: shared constants, register codes and state type of the seed hit filter
// used by sdf_if, sdf_front, sdf_back and seed_hit_diagonal_filter
package sdf_pkg;

	localparam int MAX_HITS_DEF = 64;
	localparam int POS_BITS_DEF = 16;
	localparam int ID_W         = 32;
	localparam int CFG_W        = 7;
	localparam int CFG_IDX_W    = 1;

	localparam logic [CFG_W-1:0] HIGH_MIN_RST = CFG_W'(3);
	localparam logic [CFG_W-1:0] LOW_MIN_RST  = CFG_W'(2);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HIGH_MIN = 1'b0,
		CFG_LOW_MIN  = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RUN,
		BK_DRAIN,
		BK_FIN
	} back_state_t;

endpackage

@@ hw/rtl/sdf_if.sv @@
// sdf_hit_if / sdf_res_if: valid-ready channels for hits and decisions
// depends on sdf_pkg for the id width
interface sdf_hit_if #(
	parameter int POS_BITS = sdf_pkg::POS_BITS_DEF
);
	logic                     valid;
	logic                     ready;
	logic [sdf_pkg::ID_W-1:0] tgt_id;
	logic                     freq_class;
	logic [POS_BITS-1:0]      query_pos;
	logic [POS_BITS-1:0]      target_pos;
	logic                     last_hit;

	modport source (output valid, tgt_id, freq_class, query_pos, target_pos, last_hit,
		input ready);
	modport sink (input valid, tgt_id, freq_class, query_pos, target_pos, last_hit,
		output ready);
endinterface

interface sdf_res_if;
	logic                     valid;
	logic                     ready;
	logic [sdf_pkg::ID_W-1:0] result_id;
	logic                     accepted;
	logic                     overflowed;

	modport source (output valid, result_id, accepted, overflowed, input ready);
	modport sink (input valid, result_id, accepted, overflowed, output ready);
endinterface

@@ hw/rtl/sdf_front.sv @@
// sdf_front: takes hits, writes them to the store, closes lists into jobs
// depends on sdf_pkg and sdf_hit_if
module sdf_front #(
	parameter int MAX_HITS = sdf_pkg::MAX_HITS_DEF,
	parameter int POS_BITS = sdf_pkg::POS_BITS_DEF,
	localparam int CW = $clog2(MAX_HITS + 1),
	localparam int IW = $clog2(MAX_HITS),
	localparam int JW = sdf_pkg::ID_W + 3 + CW
) (
	input  logic                           clk,
	input  logic                           arst_n,
	sdf_hit_if.sink                        hit,
	input  logic                           cfg_wr_en,
	input  logic [sdf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sdf_pkg::CFG_W-1:0]      cfg_data,
	output logic                           wr_en,
	output logic                           wr_bank,
	output logic [IW-1:0]                  wr_idx,
	output logic [2*POS_BITS-1:0]          wr_data,
	output logic                           push,
	output logic [JW-1:0]                  job,
	input  logic                           q_full,
	input  logic                           done,
	input  logic                           done_bank
);
	localparam int CMPW = (CW > sdf_pkg::CFG_W) ? CW : sdf_pkg::CFG_W;

	typedef struct packed {
		logic [sdf_pkg::ID_W-1:0] id;
		logic                     ovf;
		logic                     check;
		logic                     bank;
		logic [CW-1:0]            n;
	} job_t;

	logic [sdf_pkg::CFG_W-1:0] high_min_q, low_min_q, need;
	logic [CW-1:0]             count_q, n_close;
	logic                      ovf_q, bank_q, store_full, ovf_close, acc, cnt_ok;
	logic [1:0]                busy_q;
	job_t                      job_d;

	assign store_full = (count_q == CW'(MAX_HITS));
	assign hit.ready  = !busy_q[bank_q] && !q_full;
	assign acc        = hit.valid && hit.ready;

	assign wr_en   = acc && !store_full;
	assign wr_bank = bank_q;
	assign wr_idx  = count_q[IW-1:0];
	assign wr_data = {hit.query_pos, hit.target_pos};

	assign n_close   = store_full ? count_q : count_q + CW'(1);
	assign ovf_close = ovf_q || store_full;
	assign need      = hit.freq_class ? low_min_q : high_min_q;
	assign cnt_ok    = CMPW'(n_close) >= CMPW'(need);

	always_comb begin
		job_d.id    = hit.tgt_id;
		job_d.ovf   = ovf_close;
		job_d.check = !ovf_close && cnt_ok;
		job_d.bank  = bank_q;
		job_d.n     = n_close;
	end

	assign push = acc && hit.last_hit;
	assign job  = job_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_min_q <= sdf_pkg::HIGH_MIN_RST;
			low_min_q  <= sdf_pkg::LOW_MIN_RST;
		end else if (cfg_wr_en) begin
			unique case (sdf_pkg::cfg_idx_t'(cfg_index))
				sdf_pkg::CFG_HIGH_MIN: high_min_q <= cfg_data;
				sdf_pkg::CFG_LOW_MIN:  low_min_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			bank_q  <= 1'b0;
			busy_q  <= '0;
		end else begin
			if (acc) begin
				if (hit.last_hit) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
					bank_q  <= !bank_q;
				end else if (store_full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + CW'(1);
				end
			end
			for (int b = 0; b < 2; b++) begin
				if (push && (bank_q == 1'(b)))
					busy_q[b] <= 1'b1;
				else if (done && (done_bank == 1'(b)))
					busy_q[b] <= 1'b0;
			end
		end
	end
endmodule

@@ hw/rtl/sdf_queue.sv @@
// sdf_queue: two-entry job queue between front and back
// depends on nothing but its width parameter
module sdf_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         full,
	output logic         empty
);
	logic [W-1:0] mem_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (pop)
				rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

@@ hw/rtl/sdf_back.sv @@
// sdf_back: hit store and pairwise order and diagonal check of one list
// depends on sdf_pkg and sdf_res_if
module sdf_back #(
	parameter int MAX_HITS = sdf_pkg::MAX_HITS_DEF,
	parameter int POS_BITS = sdf_pkg::POS_BITS_DEF,
	localparam int CW = $clog2(MAX_HITS + 1),
	localparam int IW = $clog2(MAX_HITS),
	localparam int JW = sdf_pkg::ID_W + 3 + CW
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic                  wr_bank,
	input  logic [IW-1:0]         wr_idx,
	input  logic [2*POS_BITS-1:0] wr_data,
	input  logic [JW-1:0]         job,
	input  logic                  q_empty,
	output logic                  pop,
	output logic                  done,
	output logic                  done_bank,
	sdf_res_if.source             res
);
	typedef struct packed {
		logic [sdf_pkg::ID_W-1:0] id;
		logic                     ovf;
		logic                     check;
		logic                     bank;
		logic [CW-1:0]            n;
	} job_t;

	logic [2*POS_BITS-1:0] mem [2][MAX_HITS];

	sdf_pkg::back_state_t state_q, state_d;
	job_t                 job_in, job_q;
	logic [IW-1:0]        i_q, j_q;
	logic                 rd_en, rv_s1, inv_q, diag_q, last_pair, load_out;
	logic [2*POS_BITS-1:0] rd_a_s1, rd_b_s1;
	logic [POS_BITS-1:0]  qa, ta, qb, tb;
	logic                 out_valid_q, acc_q, ovf_q;
	logic [sdf_pkg::ID_W-1:0] id_q;

	assign job_in    = job_t'(job);
	assign last_pair = (CW'(j_q) + CW'(1) == job_q.n) && (CW'(i_q) + CW'(2) == job_q.n);

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_bank][wr_idx] <= wr_data;
		if (rd_en) begin
			rd_a_s1 <= mem[job_q.bank][i_q];
			rd_b_s1 <= mem[job_q.bank][j_q];
		end
	end

	assign {qa, ta} = rd_a_s1;
	assign {qb, tb} = rd_b_s1;

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		rd_en    = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			sdf_pkg::BK_IDLE: begin
				if (!q_empty) begin
					pop = 1'b1;
					if (job_in.check && (job_in.n >= CW'(2)))
						state_d = sdf_pkg::BK_RUN;
					else
						state_d = sdf_pkg::BK_FIN;
				end
			end
			sdf_pkg::BK_RUN: begin
				rd_en = 1'b1;
				if (last_pair)
					state_d = sdf_pkg::BK_DRAIN;
			end
			sdf_pkg::BK_DRAIN: state_d = sdf_pkg::BK_FIN;
			sdf_pkg::BK_FIN: begin
				if (!out_valid_q || res.ready) begin
					load_out = 1'b1;
					state_d  = sdf_pkg::BK_IDLE;
				end
			end
			default: state_d = sdf_pkg::BK_IDLE;
		endcase
	end

	assign done      = load_out;
	assign done_bank = job_q.bank;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sdf_pkg::BK_IDLE;
			rv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rv_s1   <= rd_en;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (res.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q  <= job_in;
			i_q    <= '0;
			j_q    <= IW'(1);
			inv_q  <= 1'b0;
			diag_q <= 1'b0;
		end else begin
			if (rd_en && !last_pair) begin
				if (CW'(j_q) + CW'(1) < job_q.n) begin
					j_q <= j_q + IW'(1);
				end else begin
					i_q <= i_q + IW'(1);
					j_q <= i_q + IW'(2);
				end
			end
			if (rv_s1) begin
				// a pair is out of order when query and target positions move in opposite directions
				if (((qa < qb) && (ta > tb)) || ((qb < qa) && (tb > ta)))
					inv_q <= 1'b1;
				// same diagonal, compared as sums to stay unsigned
				if (({1'b0, qa} + {1'b0, tb}) == ({1'b0, qb} + {1'b0, ta}))
					diag_q <= 1'b1;
			end
		end
		if (load_out) begin
			id_q  <= job_q.id;
			acc_q <= job_q.check && !inv_q && diag_q;
			ovf_q <= job_q.ovf;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.result_id  = id_q;
	assign res.accepted   = acc_q;
	assign res.overflowed = ovf_q;
endmodule

@@ hw/rtl/seed_hit_diagonal_filter.sv @@
// seed_hit_diagonal_filter: top level of the seed hit colinear diagonal filter
// depends on sdf_pkg, sdf_if, sdf_front, sdf_queue and sdf_back

// hits of one target stream in on the hit channel, one item per cycle, into one of two
// store banks; the item with last_hit closes the list and yields exactly one decision item on
// the res channel. a list is accepted when its hit count reaches the class threshold, no two
// hits cross (query up while target down) and two hits share a diagonal. lists longer than
// MAX_HITS are rejected with overflowed set. the front takes a hit every cycle; the back
// checks a closed list of n hits by reading every pair from the store through its two read
// ports, one pair per cycle. two banks and a two-entry job queue let the front fill the next
// list while the back checks the previous one; the hit channel stalls only when both banks
// hold lists not yet checked. the user must see that thresholds are written on the config
// port only while the block is idle; the block itself does not enforce this.
module seed_hit_diagonal_filter #(
	parameter int MAX_HITS = sdf_pkg::MAX_HITS_DEF,
	parameter int POS_BITS = sdf_pkg::POS_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	sdf_hit_if.sink                       hit,
	sdf_res_if.source                     res,
	input  logic                          cfg_wr_en,
	input  logic [sdf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sdf_pkg::CFG_W-1:0]     cfg_data
);
	localparam int CW = $clog2(MAX_HITS + 1);
	localparam int IW = $clog2(MAX_HITS);
	localparam int JW = sdf_pkg::ID_W + 3 + CW;

	// store write path from front to back
	logic                  wr_en, wr_bank;
	logic [IW-1:0]         wr_idx;
	logic [2*POS_BITS-1:0] wr_data;

	// job queue
	logic          push, pop, q_full, q_empty;
	logic [JW-1:0] job_in, job_out;

	// bank release from back to front
	logic done, done_bank;

	sdf_front #(.MAX_HITS(MAX_HITS), .POS_BITS(POS_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.hit       (hit),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.wr_en     (wr_en),
		.wr_bank   (wr_bank),
		.wr_idx    (wr_idx),
		.wr_data   (wr_data),
		.push      (push),
		.job       (job_in),
		.q_full    (q_full),
		.done      (done),
		.done_bank (done_bank)
	);

	sdf_queue #(.W(JW)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (job_in),
		.pop    (pop),
		.dout   (job_out),
		.full   (q_full),
		.empty  (q_empty)
	);

	sdf_back #(.MAX_HITS(MAX_HITS), .POS_BITS(POS_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_bank   (wr_bank),
		.wr_idx    (wr_idx),
		.wr_data   (wr_data),
		.job       (job_out),
		.q_empty   (q_empty),
		.pop       (pop),
		.done      (done),
		.done_bank (done_bank),
		.res       (res)
	);

	// an overflowed list is never accepted
	a_ovf_rejects: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !(res.accepted && res.overflowed))
		else $error("overflowed list accepted");

	// the front never closes a list into a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("job pushed into full queue");

	// the back only takes a job that is there
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("job popped from empty queue");
endmodule
